>>> rtl/sign_magnitude_toy_cpu_execute_macros.svh
`ifndef SIGN_MAGNITUDE_TOY_CPU_EXECUTE_MACROS_SVH
`define SIGN_MAGNITUDE_TOY_CPU_EXECUTE_MACROS_SVH

// implication checked every clock outside reset
`define SMTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence checked on the clock after the antecedent
`define SMTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/smtc_pkg.sv
`timescale 1ns / 1ps
package smtc_pkg;

  localparam int MEM_BYTES_DEF = 32768;
  localparam int NUM_REGS      = 8;
  localparam int RIDX_W        = 3;

  localparam logic [3:0] OP_HALT = 4'd0;
  localparam logic [3:0] OP_MOVE = 4'd1;
  localparam logic [3:0] OP_ADD  = 4'd2;
  localparam logic [3:0] OP_SUB  = 4'd3;
  localparam logic [3:0] OP_MUL  = 4'd4;
  localparam logic [3:0] OP_DIV  = 4'd5;
  localparam logic [3:0] OP_AND  = 4'd6;
  localparam logic [3:0] OP_OR   = 4'd7;
  localparam logic [3:0] OP_NOT  = 4'd8;
  localparam logic [3:0] OP_CMP  = 4'd9;
  localparam logic [3:0] OP_JUMP = 4'd10;
  localparam logic [3:0] OP_IN   = 4'd11;
  localparam logic [3:0] OP_OUT  = 4'd12;

  localparam logic [1:0] FLAG_EQ = 2'd0;
  localparam logic [1:0] FLAG_GT = 2'd1;
  localparam logic [1:0] FLAG_LT = 2'd2;

  localparam logic [3:0] COND_ALWAYS = 4'd0;
  localparam logic [3:0] COND_EQ     = 4'd1;
  localparam logic [3:0] COND_GT     = 4'd2;
  localparam logic [3:0] COND_LT     = 4'd3;

  localparam logic [1:0] SRC_IMM  = 2'd0;
  localparam logic [1:0] SRC_REG  = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;

  typedef struct packed {
    logic              load;
    logic              clr;
    logic              op_we;
    logic              op_b;
    logic [1:0]        osrc;
    logic [RIDX_W-1:0] ridx;
    logic              wrap_load;
    logic              wrap_step;
    logic              rd;
    logic              rd_lo;
    logic              cap_hi;
    logic              cap_lo;
    logic              exec;
    logic              mul_fin;
    logic              div_start;
    logic              div_step;
    logic              div_fin;
    logic              set_derr;
    logic              reg_we;
    logic [RIDX_W-1:0] widx;
    logic              mem_we;
    logic              mem_lo;
    logic              pc_start;
    logic              finish;
  } smtc_cmd_t;

  typedef struct packed {
    logic [3:0] func;
    logic [3:0] dsel;
    logic [3:0] ssel;
    logic       b_zero;
    logic       wrap_done;
    logic       div_done;
    logic       clr_last;
  } smtc_sts_t;

endpackage

>>> rtl/smtc_ram.sv
`timescale 1ns / 1ps
module smtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/smtc_ctrl.sv
`timescale 1ns / 1ps
module smtc_ctrl import smtc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      res_ready,
  input  smtc_sts_t sts,
  output smtc_cmd_t cmd,
  output logic      in_ready,
  output logic      res_valid
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SA    = 4'd2;
  localparam logic [3:0] S_SB    = 4'd3;
  localparam logic [3:0] S_WRAP  = 4'd4;
  localparam logic [3:0] S_RDH   = 4'd5;
  localparam logic [3:0] S_RDL   = 4'd6;
  localparam logic [3:0] S_RDC   = 4'd7;
  localparam logic [3:0] S_EXEC  = 4'd8;
  localparam logic [3:0] S_MULF  = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_WB    = 4'd11;
  localparam logic [3:0] S_WRH   = 4'd12;
  localparam logic [3:0] S_WRL   = 4'd13;
  localparam logic [3:0] S_PCS   = 4'd14;
  localparam logic [3:0] S_FIN   = 4'd15;

  localparam logic [1:0] M_A  = 2'd0;
  localparam logic [1:0] M_B  = 2'd1;
  localparam logic [1:0] M_ST = 2'd2;
  localparam logic [1:0] M_PC = 2'd3;

  localparam logic [1:0] D_NONE = 2'd0;
  localparam logic [1:0] D_REG  = 2'd1;
  localparam logic [1:0] D_MEM  = 2'd2;

  logic [3:0] state, state_next;
  logic [1:0] mode, mode_next;
  logic       res_valid_next;

  logic       d_reg, d_mem, s_reg, s_mem, d_any, s_any;
  logic       alu_op, need_a, need_b;
  logic [1:0] dkind;
  logic [RIDX_W-1:0] didx;
  logic [3:0] cur_sel;
  logic       slot_free;

  assign d_reg = sts.dsel >= 4'd1 && sts.dsel <= 4'd4;
  assign d_mem = sts.dsel >= 4'd5 && sts.dsel <= 4'd8;
  assign s_reg = sts.ssel >= 4'd1 && sts.ssel <= 4'd4;
  assign s_mem = sts.ssel >= 4'd5 && sts.ssel <= 4'd8;
  assign d_any = d_reg || d_mem;
  assign s_any = s_reg || s_mem;
  assign alu_op = sts.func >= OP_ADD && sts.func <= OP_OR;

  assign need_a = alu_op || sts.func == OP_CMP ||
                  ((sts.func == OP_NOT || sts.func == OP_OUT) && d_any);
  assign need_b = alu_op || sts.func == OP_CMP ||
                  (sts.func == OP_NOT && sts.dsel == 4'd0 && s_any) ||
                  (sts.func == OP_MOVE && d_any && s_any);

  assign cur_sel   = (state == S_SB) ? sts.ssel : sts.dsel;
  assign slot_free = !res_valid || res_ready;
  assign in_ready  = state == S_IDLE;

  always_comb begin
    dkind = D_NONE;
    didx  = RIDX_W'(sts.dsel - 4'd1);
    if (sts.func == OP_MOVE && d_any) begin
      if (sts.ssel == 4'd0 || s_mem) begin
        dkind = D_REG;
      end else if (s_reg) begin
        dkind = D_MEM;
      end
    end else if (alu_op || sts.func == OP_IN) begin
      if (d_reg) begin
        dkind = D_REG;
      end else if (d_mem) begin
        dkind = D_MEM;
      end
    end else if (sts.func == OP_NOT) begin
      if (d_any) begin
        dkind = D_REG;
      end else if (sts.dsel == 4'd0 && s_any) begin
        dkind = D_MEM;
        didx  = RIDX_W'(sts.ssel - 4'd1);
      end
    end
  end

  always_comb begin
    cmd            = '0;
    state_next     = state;
    mode_next      = mode;
    res_valid_next = res_valid && !res_ready;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SA;
        end
      end
      S_SA, S_SB: begin
        if ((state == S_SA) ? need_a : need_b) begin
          cmd.ridx = RIDX_W'(cur_sel - 4'd1);
          cmd.op_b = state == S_SB;
          if (cur_sel >= 4'd5 && cur_sel <= 4'd8) begin
            cmd.wrap_load = 1'b1;
            mode_next     = (state == S_SB) ? M_B : M_A;
            state_next    = S_WRAP;
          end else begin
            cmd.op_we = 1'b1;
            if (cur_sel == 4'd0) begin
              cmd.osrc = SRC_IMM;
            end else if (cur_sel <= 4'd4) begin
              cmd.osrc = SRC_REG;
            end else begin
              cmd.osrc = SRC_ZERO;
            end
            state_next = (state == S_SB) ? S_EXEC : S_SB;
          end
        end else begin
          state_next = (state == S_SB) ? S_EXEC : S_SB;
        end
      end
      S_WRAP: begin
        if (sts.wrap_done) begin
          unique case (mode)
            M_A, M_B: state_next = S_RDH;
            M_ST:     state_next = S_WRH;
            M_PC:     state_next = S_FIN;
            default:  state_next = S_FIN;
          endcase
        end else begin
          cmd.wrap_step = 1'b1;
        end
      end
      S_RDH: begin
        cmd.rd     = 1'b1;
        state_next = S_RDL;
      end
      S_RDL: begin
        cmd.cap_hi = 1'b1;
        cmd.rd     = 1'b1;
        cmd.rd_lo  = 1'b1;
        state_next = S_RDC;
      end
      S_RDC: begin
        cmd.cap_lo = 1'b1;
        cmd.op_b   = mode == M_B;
        state_next = (mode == M_B) ? S_EXEC : S_SB;
      end
      S_EXEC: begin
        if (sts.func == OP_DIV) begin
          if (sts.b_zero) begin
            cmd.set_derr = 1'b1;
            state_next   = S_PCS;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end
        end else begin
          cmd.exec   = 1'b1;
          state_next = (sts.func == OP_MUL) ? S_MULF : S_WB;
        end
      end
      S_MULF: begin
        cmd.mul_fin = 1'b1;
        state_next  = S_WB;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_fin = 1'b1;
          state_next  = S_WB;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_WB: begin
        cmd.widx = didx;
        cmd.ridx = didx;
        unique case (dkind)
          D_REG: begin
            cmd.reg_we = 1'b1;
            state_next = S_PCS;
          end
          D_MEM: begin
            cmd.wrap_load = 1'b1;
            mode_next     = M_ST;
            state_next    = S_WRAP;
          end
          default: state_next = S_PCS;
        endcase
      end
      S_WRH: begin
        cmd.mem_we = 1'b1;
        state_next = S_WRL;
      end
      S_WRL: begin
        cmd.mem_we = 1'b1;
        cmd.mem_lo = 1'b1;
        state_next = S_PCS;
      end
      S_PCS: begin
        cmd.pc_start = 1'b1;
        mode_next    = M_PC;
        state_next   = S_WRAP;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.finish     = 1'b1;
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      mode      <= M_A;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      mode      <= mode_next;
      res_valid <= res_valid_next;
    end
  end

endmodule

>>> rtl/smtc_dpath.sv
`timescale 1ns / 1ps
module smtc_dpath import smtc_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  smtc_cmd_t          cmd,
  output smtc_sts_t          sts,
  input  logic [3:0]         func,
  input  logic [3:0]         dest_sel,
  input  logic [3:0]         src_sel,
  input  logic signed [15:0] imm,
  input  logic signed [15:0] in_value,
  output logic [14:0]        next_ip,
  output logic [1:0]         flag_state,
  output logic               out_valid,
  output logic signed [15:0] out_value,
  output logic               halted,
  output logic               div_error
);

  localparam int AW  = $clog2(MEM_BYTES);
  localparam int WVW = (AW + 2 > 17) ? AW + 2 : 17;
  localparam logic [WVW-1:0] M_W     = WVW'(MEM_BYTES);
  localparam logic [WVW-1:0] PC_STEP = WVW'(4);
  localparam logic [AW-1:0]  A_LAST  = AW'(MEM_BYTES - 1);

  logic [15:0] rf [NUM_REGS];
  logic [1:0]  flag;
  logic [AW-1:0] pc;
  logic [AW-1:0] clr_cnt;

  logic [3:0]  fn, ds, ss;
  logic [15:0] immw, inw;
  logic [15:0] opa, opb, res;
  logic [7:0]  hi_byte;
  logic [WVW-1:0] wv;
  logic [29:0] prod;
  logic        psign;
  logic [14:0] dq, drem;
  logic [3:0]  dcnt;
  logic        dsign;
  logic        derr;

  logic [15:0] imm_abs, in_abs, rd_word, op_val;
  logic [WVW-1:0] rd_sv, imm_sv;
  logic        wrap_done, take;
  logic [AW-1:0] addr, addr_nx;
  logic        ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]  ram_wdata, ram_rdata;
  logic [14:0] ma, mb;
  logic        sa, sb;
  logic [17:0] a_v, b_v, sum, sum_abs;
  logic [15:0] as_res;
  logic [1:0]  cmp_res;
  logic [15:0] trial;
  logic        dout_en;

  assign imm_abs = imm[15] ? (16'd0 - imm) : imm;
  assign in_abs  = in_value[15] ? (16'd0 - in_value) : in_value;
  assign rd_word = rf[cmd.ridx];
  assign rd_sv   = rd_word[15] ? (WVW'(0) - WVW'(rd_word[14:0])) : WVW'(rd_word[14:0]);
  assign imm_sv  = immw[15] ? (WVW'(0) - WVW'(immw[14:0])) : WVW'(immw[14:0]);
  assign wrap_done = !wv[WVW-1] && (wv < M_W);
  assign addr    = wv[AW-1:0];
  assign addr_nx = (addr == A_LAST) ? '0 : addr + 1'b1;

  assign take = fn == OP_JUMP &&
                (ss == COND_ALWAYS || (ss == COND_EQ && flag == FLAG_EQ) ||
                 (ss == COND_GT && flag == FLAG_GT) || (ss == COND_LT && flag == FLAG_LT));

  always_comb begin
    unique case (cmd.osrc)
      SRC_IMM: op_val = immw;
      SRC_REG: op_val = rd_word;
      default: op_val = 16'd0;
    endcase
  end

  assign ma = opa[14:0];
  assign mb = opb[14:0];
  assign sa = opa[15];
  assign sb = opb[15];
  assign a_v = sa ? (18'd0 - 18'(ma)) : 18'(ma);
  assign b_v = sb ? (18'd0 - 18'(mb)) : 18'(mb);
  assign sum = (fn == OP_SUB) ? (a_v - b_v) : (a_v + b_v);
  assign sum_abs = sum[17] ? (18'd0 - sum) : sum;
  assign as_res  = {sum[17], sum_abs[14:0]};

  always_comb begin
    priority if (opa == opb) begin
      cmp_res = FLAG_EQ;
    end else if (sa != sb) begin
      cmp_res = sa ? FLAG_LT : FLAG_GT;
    end else if ((ma > mb) != sa) begin
      cmp_res = FLAG_GT;
    end else begin
      cmp_res = FLAG_LT;
    end
  end

  assign trial   = {drem, dq[14]};
  assign dout_en = fn == OP_OUT && ds >= 4'd1 && ds <= 4'd8;

  assign ram_we    = cmd.clr || cmd.mem_we;
  assign ram_waddr = cmd.clr ? clr_cnt : (cmd.mem_lo ? addr_nx : addr);
  assign ram_wdata = cmd.clr ? 8'd0 : (cmd.mem_lo ? res[7:0] : res[15:8]);
  assign ram_raddr = cmd.rd_lo ? addr_nx : addr;

  smtc_ram #(
    .WIDTH (8),
    .DEPTH (MEM_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sts.func      = fn;
  assign sts.dsel      = ds;
  assign sts.ssel      = ss;
  assign sts.b_zero    = mb == 15'd0;
  assign sts.wrap_done = wrap_done;
  assign sts.div_done  = dcnt == 4'd0;
  assign sts.clr_last  = clr_cnt == A_LAST;

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        rf[i] <= 16'd0;
      end
      flag    <= FLAG_EQ;
      pc      <= '0;
      clr_cnt <= '0;
    end else begin
      if (cmd.clr) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.reg_we) begin
        rf[cmd.widx] <= res;
      end
      if (cmd.exec && fn == OP_CMP) begin
        flag <= cmp_res;
      end
      if (cmd.finish) begin
        pc <= addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fn   <= func;
      ds   <= dest_sel;
      ss   <= src_sel;
      immw <= (imm == 16'sh8000) ? 16'd0 : {imm[15], imm_abs[14:0]};
      inw  <= {in_value[15], in_abs[14:0]};
      derr <= 1'b0;
    end
    if (cmd.set_derr) begin
      derr <= 1'b1;
    end
    if (cmd.op_we) begin
      if (cmd.op_b) begin
        opb <= op_val;
      end else begin
        opa <= op_val;
      end
    end
    if (cmd.cap_hi) begin
      hi_byte <= ram_rdata;
    end
    if (cmd.cap_lo) begin
      if (cmd.op_b) begin
        opb <= {hi_byte, ram_rdata};
      end else begin
        opa <= {hi_byte, ram_rdata};
      end
    end
    if (cmd.wrap_load) begin
      wv <= rd_sv;
    end else if (cmd.pc_start) begin
      wv <= WVW'(pc) + (take ? imm_sv : PC_STEP);
    end else if (cmd.wrap_step) begin
      wv <= wv[WVW-1] ? (wv + M_W) : (wv - M_W);
    end
    if (cmd.exec) begin
      unique case (fn)
        OP_MOVE:        res <= (ss == 4'd0) ? immw : opb;
        OP_ADD, OP_SUB: res <= as_res;
        OP_MUL: begin
          prod  <= ma * mb;
          psign <= sa ^ sb;
        end
        OP_AND:  res <= {15'd0, (opa != 16'd0) && (opb != 16'd0)};
        OP_OR:   res <= {15'd0, (opa != 16'd0) || (opb != 16'd0)};
        OP_NOT:  res <= {15'd0, (ds == 4'd0) ? (opb == 16'd0) : (opa == 16'd0)};
        OP_IN:   res <= inw;
        default: res <= res;
      endcase
    end
    if (cmd.mul_fin) begin
      res <= {psign && (prod != 30'd0), prod[14:0]};
    end
    if (cmd.div_start) begin
      dq    <= ma;
      drem  <= 15'd0;
      dcnt  <= 4'd15;
      dsign <= sa ^ sb;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, mb}) begin
        drem <= 15'(trial - {1'b0, mb});
        dq   <= {dq[13:0], 1'b1};
      end else begin
        drem <= trial[14:0];
        dq   <= {dq[13:0], 1'b0};
      end
      dcnt <= dcnt - 4'd1;
    end
    if (cmd.div_fin) begin
      res <= {dsign && (dq != 15'd0), dq};
    end
    if (cmd.finish) begin
      next_ip    <= wv[14:0];
      flag_state <= flag;
      out_valid  <= dout_en;
      out_value  <= !dout_en ? 16'sd0 :
                    (sa ? (16'd0 - {1'b0, ma}) : {1'b0, ma});
      halted     <= fn == OP_HALT;
      div_error  <= derr;
    end
  end

endmodule

>>> rtl/sign_magnitude_toy_cpu_execute.sv
// channel   signals                               direction
// request   in_valid, in_ready, func, dest_sel,   in
//           src_sel, imm, in_value
// result    res_valid, res_ready, next_ip,        out
//           flag_state, out_valid, out_value,
//           halted, div_error
//
// one instruction at a time; multiply adds a finishing step, each memory operand
// adds an address wrap and two byte reads, a store two byte writes; divide is 1-bit restoring
// each memory address or pc wrap removes one multiple of MEM_BYTES per step until in
// range; data store is one byte-wide ram port, a word takes two accesses
// after reset the data store is cleared byte by byte, in_ready low
// a result waiting on res_ready stalls only the final write of the next one
`timescale 1ns / 1ps
module sign_magnitude_toy_cpu_execute import smtc_pkg::*; #(
  parameter int MEM_BYTES = MEM_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         func,
  input  logic [3:0]         dest_sel,
  input  logic [3:0]         src_sel,
  input  logic signed [15:0] imm,
  input  logic signed [15:0] in_value,
  output logic               res_valid,
  input  logic               res_ready,
  output logic [14:0]        next_ip,
  output logic [1:0]         flag_state,
  output logic               out_valid,
  output logic signed [15:0] out_value,
  output logic               halted,
  output logic               div_error
);

  smtc_cmd_t cmd;
  smtc_sts_t sts;

  smtc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .res_ready (res_ready),
    .sts       (sts),
    .cmd       (cmd),
    .in_ready  (in_ready),
    .res_valid (res_valid)
  );

  smtc_dpath #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .func       (func),
    .dest_sel   (dest_sel),
    .src_sel    (src_sel),
    .imm        (imm),
    .in_value   (in_value),
    .next_ip    (next_ip),
    .flag_state (flag_state),
    .out_valid  (out_valid),
    .out_value  (out_value),
    .halted     (halted),
    .div_error  (div_error)
  );

endmodule

>>> rtl/smtc_checker.sv
`timescale 1ns / 1ps
`include "sign_magnitude_toy_cpu_execute_macros.svh"
module smtc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               res_valid,
  input logic               res_ready,
  input logic [14:0]        next_ip,
  input logic [1:0]         flag_state,
  input logic               out_valid,
  input logic signed [15:0] out_value,
  input logic               halted,
  input logic               div_error
);

  `SMTC_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while busy")
  `SMTC_ASSERT_IMP(a_flag_code, res_valid, flag_state != 2'd3, "bad compare flag")
  `SMTC_ASSERT_IMP(a_flags_excl, res_valid && halted, !out_valid && !div_error, "flags overlap")
  `SMTC_ASSERT_IMP(a_out_zero, res_valid && !out_valid, out_value == 16'sd0, "stray out value")
  `SMTC_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(next_ip), "result dropped")

endmodule

bind sign_magnitude_toy_cpu_execute smtc_checker u_chk (.*);
